// ===== rtl/gbs_pkg.sv =====
package gbs_pkg;

    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam int THR_W   = 16;
    localparam int BOXNO_W = 16;

    localparam logic [THR_W-1:0]   THR_RESET = 16'd29491;
    localparam logic [BOXNO_W-1:0] BOXNO_MAX = 16'hFFFF;

    typedef struct packed {
        logic wr_en;
    } t_cell_ctl;

endpackage

// ===== rtl/gbs_cell.sv =====
module gbs_cell
    import gbs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [THR_W-1:0]        i_thr,
    input  logic [CNT_W-1:0]        i_count,
    input  t_cell_ctl               i_ctl,
    input  logic [COORD_BITS-1:0]   i_x,
    input  logic [COORD_BITS-1:0]   i_y,
    input  logic [COORD_BITS-1:0]   i_w,
    input  logic [COORD_BITS-1:0]   i_h,
    input  logic [2*COORD_BITS-1:0] i_area,
    input  logic                    i_sup,
    output logic [COORD_BITS-1:0]   o_x,
    output logic [COORD_BITS-1:0]   o_y,
    output logic [COORD_BITS-1:0]   o_w,
    output logic [COORD_BITS-1:0]   o_h,
    output logic [2*COORD_BITS-1:0] o_area,
    output logic                    o_sup
);

    localparam int C      = COORD_BITS;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int SUM_W  = AREA_W + 1;
    localparam int PROD_W = THR_W + SUM_W;

    logic [C-1:0]      r_kx, r_ky, r_kw, r_kh;
    logic [AREA_W-1:0] r_karea;

    logic [C-1:0]      r_iw, r_ih;
    logic              r_act1;
    logic [AREA_W-1:0] r_area1;

    logic [AREA_W-1:0] r_inter2;
    logic [SUM_W-1:0]  r_asum2;
    logic              r_act2;

    logic [AREA_W-1:0] r_inter3;
    logic [PROD_W-1:0] r_prod3;
    logic              r_act3;

    logic              r_sup;

    logic [C-1:0]      lo_x, lo_y;
    logic [C:0]        hi_x, hi_y, ae_x, be_x, ae_y, be_y;
    logic [C:0]        dx, dy;
    logic [C-1:0]      n_iw, n_ih;
    logic [SUM_W-1:0]  uni;
    logic [PROD_W-1:0] lhs;
    logic              hit;
    logic              wr_here;

    assign wr_here = i_ctl.wr_en && (i_count == CNT_W'(INDEX));

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_kx    <= i_x;
            r_ky    <= i_y;
            r_kw    <= i_w;
            r_kh    <= i_h;
            r_karea <= i_area;
        end
    end

    always_comb begin
        lo_x = (i_x > r_kx) ? i_x : r_kx;
        lo_y = (i_y > r_ky) ? i_y : r_ky;
        ae_x = {1'b0, i_x} + {1'b0, i_w};
        be_x = {1'b0, r_kx} + {1'b0, r_kw};
        ae_y = {1'b0, i_y} + {1'b0, i_h};
        be_y = {1'b0, r_ky} + {1'b0, r_kh};
        hi_x = (ae_x < be_x) ? ae_x : be_x;
        hi_y = (ae_y < be_y) ? ae_y : be_y;
        dx   = hi_x - {1'b0, lo_x};
        dy   = hi_y - {1'b0, lo_y};
        n_iw = (hi_x > {1'b0, lo_x}) ? dx[C-1:0] : '0;
        n_ih = (hi_y > {1'b0, lo_y}) ? dy[C-1:0] : '0;
    end

    assign uni = r_asum2 - {1'b0, r_inter2};
    assign lhs = {{(PROD_W-AREA_W-THR_W){1'b0}}, r_inter3, {THR_W{1'b0}}};
    assign hit = r_act3 && (lhs > r_prod3);

    always_ff @(posedge i_clk) begin
        o_x     <= i_x;
        o_y     <= i_y;
        o_w     <= i_w;
        o_h     <= i_h;
        o_area  <= i_area;
        r_iw    <= n_iw;
        r_ih    <= n_ih;
        r_area1 <= i_area;
        r_inter2 <= r_iw * r_ih;
        r_asum2  <= {1'b0, r_area1} + {1'b0, r_karea};
        r_inter3 <= r_inter2;
        r_prod3  <= i_thr * uni;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act1 <= 1'b0;
            r_act2 <= 1'b0;
            r_act3 <= 1'b0;
            r_sup  <= 1'b0;
        end else begin
            r_act1 <= (CNT_W'(INDEX) < i_count);
            r_act2 <= r_act1;
            r_act3 <= r_act2;
            r_sup  <= i_sup | hit;
        end
    end

    assign o_sup = r_sup;

endmodule

// ===== rtl/greedy_box_suppression_core.sv =====
// Greedy non-maximum suppression over boxes that arrive sorted by falling score.
// Each box walks a row of MAX_KEPT compare cells, one cell per cycle, each cell
// holding one kept box and running a four-stage overlap, union and threshold test;
// a box's result is written to the output register once that register is empty or
// its result is being taken, and only one box is handled at a time. The next box
// is accepted as soon as the previous result sits in the output register, even
// while that result waits to be taken. A box with first_of_set high empties the
// kept list and restarts box numbering. The threshold register may be written
// only while no box is in flight.
module greedy_box_suppression_core
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CNT_W      = $clog2(MAX_KEPT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [THR_W-1:0]      i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    input  logic                  i_first_of_set,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BOXNO_W-1:0]    o_box_number,
    output logic                  o_keep,
    output logic [CNT_W-1:0]      o_kept_total,
    output logic                  o_list_full
);

    localparam int AREA_W    = 2 * COORD_BITS;
    localparam int SCAN_LAST = MAX_KEPT + 3;
    localparam int SCAN_W    = $clog2(SCAN_LAST + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_AREA = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                r_state;
    logic [THR_W-1:0]      r_thr;
    logic [COORD_BITS-1:0] r_x, r_y, r_w, r_h;
    logic [AREA_W-1:0]     r_area;
    logic [CNT_W-1:0]      r_count;
    logic [BOXNO_W-1:0]    r_boxctr;
    logic [BOXNO_W-1:0]    r_number;
    logic [SCAN_W-1:0]     r_scan;
    logic                  r_out_valid;
    logic [BOXNO_W-1:0]    r_out_number;
    logic                  r_out_keep;
    logic [CNT_W-1:0]      r_out_total;
    logic                  r_out_full;

    logic                  in_fire;
    logic                  done_fire;
    logic                  keep_w;
    logic                  full_w;
    t_cell_ctl             cell_ctl;

    logic [COORD_BITS-1:0] ch_x    [MAX_KEPT+1];
    logic [COORD_BITS-1:0] ch_y    [MAX_KEPT+1];
    logic [COORD_BITS-1:0] ch_w    [MAX_KEPT+1];
    logic [COORD_BITS-1:0] ch_h    [MAX_KEPT+1];
    logic [AREA_W-1:0]     ch_area [MAX_KEPT+1];
    logic                  ch_sup  [MAX_KEPT+1];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign done_fire  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign keep_w     = !ch_sup[MAX_KEPT];
    assign full_w     = keep_w && (r_count == CNT_W'(MAX_KEPT));

    assign cell_ctl.wr_en = done_fire && keep_w && !full_w;

    assign ch_x[0]    = r_x;
    assign ch_y[0]    = r_y;
    assign ch_w[0]    = r_w;
    assign ch_h[0]    = r_h;
    assign ch_area[0] = r_area;
    assign ch_sup[0]  = 1'b0;

    for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
        gbs_cell #(
            .COORD_BITS (COORD_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_thr   (r_thr),
            .i_count (r_count),
            .i_ctl   (cell_ctl),
            .i_x     (ch_x[k]),
            .i_y     (ch_y[k]),
            .i_w     (ch_w[k]),
            .i_h     (ch_h[k]),
            .i_area  (ch_area[k]),
            .i_sup   (ch_sup[k]),
            .o_x     (ch_x[k+1]),
            .o_y     (ch_y[k+1]),
            .o_w     (ch_w[k+1]),
            .o_h     (ch_h[k+1]),
            .o_area  (ch_area[k+1]),
            .o_sup   (ch_sup[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_box_x;
            r_y <= i_box_y;
            r_w <= i_box_width;
            r_h <= i_box_height;
        end
        if (r_state == S_AREA) begin
            r_area <= r_w * r_h;
        end
        if (done_fire) begin
            r_out_number <= r_number;
            r_out_keep   <= keep_w;
            r_out_full   <= full_w;
            r_out_total  <= cell_ctl.wr_en ? (r_count + CNT_W'(1)) : r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_count     <= '0;
            r_boxctr    <= '0;
            r_number    <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_first_of_set) begin
                            r_count  <= '0;
                            r_number <= '0;
                            r_boxctr <= BOXNO_W'(1);
                        end else begin
                            r_number <= r_boxctr;
                            if (r_boxctr != BOXNO_MAX) begin
                                r_boxctr <= r_boxctr + BOXNO_W'(1);
                            end
                        end
                        r_state <= S_AREA;
                    end
                end
                S_AREA: begin
                    r_scan  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_scan <= r_scan + SCAN_W'(1);
                    if (r_scan == SCAN_W'(SCAN_LAST)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        if (cell_ctl.wr_en) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_box_number = r_out_number;
    assign o_keep       = r_out_keep;
    assign o_kept_total = r_out_total;
    assign o_list_full  = r_out_full;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEPT))
        else $error("kept count exceeds the list depth");

    a_full_needs_keep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_keep || !r_out_full))
        else $error("list_full reported for a suppressed box");

    a_count_rise : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > $past(r_count)) |-> ($past(r_state) == S_DONE))
        else $error("kept count grew outside the result step");

    a_store_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.wr_en |=> (r_count == $past(r_count) + CNT_W'(1)) && r_out_valid)
        else $error("stored box did not advance the kept count");

endmodule

// ===== verif/testbench.sv =====
module testbench
    import gbs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB        = COORD_BITS_DEF;
    localparam int MK        = MAX_KEPT_DEF;
    localparam int CNT_W     = $clog2(MK + 1);
    localparam int COORD_TOP = (1 << CB) - 1;
    localparam int LIMIT     = 1000000;

    typedef struct {
        bit [CB-1:0] x;
        bit [CB-1:0] y;
        bit [CB-1:0] w;
        bit [CB-1:0] h;
        bit          first;
    } t_box;

    typedef struct {
        bit [BOXNO_W-1:0] number;
        bit               keep;
        bit [CNT_W-1:0]   total;
        bit               full;
    } t_verdict;

    class t_predictor;
        bit [THR_W-1:0]   threshold;
        bit [CB-1:0]      kept_x[MK];
        bit [CB-1:0]      kept_y[MK];
        bit [CB-1:0]      kept_w[MK];
        bit [CB-1:0]      kept_h[MK];
        bit [63:0]        kept_area[MK];
        int unsigned      kept_count;
        bit [BOXNO_W-1:0] box_count;
        t_verdict         pending_verdicts[$];
        int               errors;

        function new();
            threshold  = THR_RESET;
            kept_count = 0;
            box_count  = 0;
            errors     = 0;
        endfunction

        function bit [63:0] span(bit [63:0] a0, bit [63:0] al, bit [63:0] b0, bit [63:0] bl);
            bit [63:0] lo;
            bit [63:0] hi;
            lo = (a0 > b0) ? a0 : b0;
            hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
            return (hi > lo) ? (hi - lo) : 64'd0;
        endfunction

        function void accept_box(t_box b);
            bit [63:0] area;
            bit [63:0] inter;
            bit [63:0] uni;
            t_verdict  v;
            if (b.first) begin
                kept_count = 0;
                box_count  = 0;
            end
            v.number = box_count;
            if (box_count != BOXNO_MAX) begin
                box_count++;
            end
            area   = 64'(b.w) * 64'(b.h);
            v.keep = 1'b1;
            v.full = 1'b0;
            for (int j = 0; j < kept_count; j++) begin
                inter = span(b.x, b.w, kept_x[j], kept_w[j]) *
                        span(b.y, b.h, kept_y[j], kept_h[j]);
                uni   = area + kept_area[j] - inter;
                if (uni != 0 && (inter << 16) > 64'(threshold) * uni) begin
                    v.keep = 1'b0;
                end
            end
            if (v.keep) begin
                if (kept_count < MK) begin
                    kept_x[kept_count]    = b.x;
                    kept_y[kept_count]    = b.y;
                    kept_w[kept_count]    = b.w;
                    kept_h[kept_count]    = b.h;
                    kept_area[kept_count] = area;
                    kept_count++;
                end else begin
                    v.full = 1'b1;
                end
            end
            v.total = CNT_W'(kept_count);
            pending_verdicts = {pending_verdicts, v};
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with no expectation: box_number %0d keep %0d",
                         $time, got.number, got.keep);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            compare("box_number", want.number, got.number);
            compare("keep", want.keep, got.keep);
            compare("kept_total", want.total, got.total);
            compare("list_full", want.full, got.full);
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_wr_en    = 1'b0;
    logic [THR_W-1:0]   i_cfg_wr_data  = '0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [CB-1:0]      i_box_x        = '0;
    logic [CB-1:0]      i_box_y        = '0;
    logic [CB-1:0]      i_box_width    = '0;
    logic [CB-1:0]      i_box_height   = '0;
    logic               i_first_of_set = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [BOXNO_W-1:0] o_box_number;
    logic               o_keep;
    logic [CNT_W-1:0]   o_kept_total;
    logic               o_list_full;

    t_predictor predictor = new();
    int         send_idle = 9;
    int         recv_idle = 77;
    int         sent      = 0;
    int         cycles    = 0;

    greedy_box_suppression_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_first_of_set (i_first_of_set),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_box_number   (o_box_number),
        .o_keep         (o_keep),
        .o_kept_total   (o_kept_total),
        .o_list_full    (o_list_full)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** greedy_box_suppression_core: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            predictor.check_verdict(t_verdict'{o_box_number, o_keep, o_kept_total, o_list_full});
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic bit [CB-1:0] to_coord(int v);
        return (v < 0) ? '0 : (v > COORD_TOP) ? CB'(COORD_TOP) : CB'(v);
    endfunction

    function automatic t_box make_box(int x, int y, int w, int h, bit first);
        t_box b;
        b.x     = to_coord(x);
        b.y     = to_coord(y);
        b.w     = to_coord(w);
        b.h     = to_coord(h);
        b.first = first;
        return b;
    endfunction

    task automatic send_box(t_box b);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_box_x        <= b.x;
        i_box_y        <= b.y;
        i_box_width    <= b.w;
        i_box_height   <= b.h;
        i_first_of_set <= b.first;
        do @(posedge i_clk); while (!o_in_ready);
        predictor.accept_box(b);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (predictor.pending_verdicts.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_threshold(bit [THR_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        predictor.threshold = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_boxes();
        send_box(make_box(0, 0, 0, 0, 1'b1));
        send_box(make_box(0, 0, 0, 0, 1'b0));
        send_box(make_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1'b0));
        send_box(make_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1'b0));
        send_box(make_box(0, 0, 100, 100, 1'b0));
        send_box(make_box(100, 0, 100, 100, 1'b0));
        send_box(make_box(10, 10, 100, 100, 1'b0));
        send_box(make_box(50, 0, 100, 100, 1'b0));
        send_box(make_box(20, 20, 0, 50, 1'b0));
        send_box(make_box(20, 20, 50, 0, 1'b0));
        send_box(make_box(0, 0, COORD_TOP, COORD_TOP, 1'b0));
        send_box(make_box(10, 10, 100, 100, 1'b1));
        write_threshold('0);
        send_box(make_box(0, 0, 50, 50, 1'b1));
        send_box(make_box(49, 49, 10, 10, 1'b0));
        send_box(make_box(50, 50, 10, 10, 1'b0));
        send_box(make_box(50, 0, 10, 50, 1'b0));
        write_threshold('1);
        send_box(make_box(0, 0, 50, 50, 1'b1));
        send_box(make_box(0, 0, 50, 50, 1'b0));
        send_box(make_box(0, 0, 50, 49, 1'b0));
        send_box(make_box(5, 5, 0, 0, 1'b0));
        send_box(make_box(5, 5, 0, 0, 1'b0));
    endtask

    task automatic cluster_set();
        int n;
        int centers;
        int c;
        int cx[4];
        int cy[4];
        int cs[4];
        t_box b;
        n       = $urandom_range(2, 24);
        centers = $urandom_range(1, 4);
        for (int i = 0; i < centers; i++) begin
            cx[i] = $urandom_range(0, 3900);
            cy[i] = $urandom_range(0, 3900);
            cs[i] = ($urandom_range(7) == 0) ? $urandom_range(400, 2500) : $urandom_range(4, 400);
        end
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(0, centers - 1);
            b = make_box(cx[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4,
                         cy[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4,
                         cs[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4,
                         cs[c] + int'($urandom_range(0, cs[c] / 2)) - cs[c] / 4,
                         k == 0);
            if ($urandom_range(19) == 0) begin
                b.w = '0;
            end
            send_box(b);
        end
    endtask

    task automatic grid_set();
        int n;
        n = $urandom_range(MK + 1, MK + 8);
        for (int k = 0; k < n; k++) begin
            send_box(make_box((k % 16) * 256 + $urandom_range(0, 50),
                              (k / 16) * 256 + $urandom_range(0, 50),
                              $urandom_range(0, 200), $urandom_range(0, 200), k == 0));
        end
    endtask

    task automatic noise_burst();
        t_box b;
        repeat ($urandom_range(1, 6)) begin
            b.x     = CB'($urandom());
            b.y     = CB'($urandom());
            b.w     = CB'($urandom());
            b.h     = CB'($urandom());
            b.first = ($urandom_range(3) == 0);
            send_box(b);
        end
    endtask

    initial begin
        int target;
        bit [THR_W-1:0] thr;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_boxes();
        target = sent;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 9 : (mode == 1) ? 77 : 0;
            recv_idle = (mode == 0) ? 77 : (mode == 1) ? 9 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                case (mode * 2 + sub)
                    0: thr = THR_RESET;
                    2: thr = '0;
                    3: thr = '1;
                    5: thr = 16'h8000;
                    default: thr = THR_W'($urandom());
                endcase
                write_threshold(thr);
                target += 125;
                if (sub == 0) begin
                    grid_set();
                end
                while (sent < target) begin
                    if ($urandom_range(9) < 7) begin
                        cluster_set();
                    end else begin
                        noise_burst();
                    end
                end
            end
        end
        drain();
        repeat (MK + 16) @(posedge i_clk);
        if (predictor.errors == 0 && predictor.pending_verdicts.size() == 0) begin
            $display("** greedy_box_suppression_core: PASSED **");
        end else begin
            $display("** greedy_box_suppression_core: FAILED **");
        end
        $finish;
    end

endmodule
